>>> hw/rtl/ale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array list engine package
// Field widths, operation codes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int MODE_W = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 6;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // latch a new request
        logic decode;        // set ok, clear read value and found position
        logic clr_count;
        logic inc_count;
        logic dec_count;
        logic ptr_load_pos;  // pointer <= position - 1
        logic ptr_load_cnt;  // pointer <= length - 1
        logic ptr_load_zero;
        logic issue;         // read at the pointer, then step it
        logic dir_up;        // step the pointer up rather than down
        logic shift_wr;      // write the last read entry one place over
        logic shift_up;      // that place is above rather than below
        logic wr_value;      // write the request value at position - 1
        logic capture;       // keep the last read entry as read value
        logic found_rec;     // keep the last read place as found position
    } ale_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic get_ok;        // position addresses a stored entry
        logic ins_ok;        // room left and position within length + 1
        logic ins_tail;      // insert at the end, nothing to move
        logic del_more;      // entries above the deleted one
        logic count_zero;
        logic ptr_last_cnt;  // pointer at the top entry
        logic ptr_last_pos;  // pointer at position - 1
        logic hit;           // last read entry equals the request value
    } ale_stat_t;

endpackage : ale_pkg
`default_nettype wire

>>> hw/rtl/ale_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array list engine controller
// Sequences decode, scan and shift steps and raises the result strobe.
// ----------------------------------------------------------------------------
module ale_ctrl
    import ale_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire ale_stat_t stat,
    output ale_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_RD_ISSUE  = 4'd2;
    localparam logic [3:0] S_GET_CAPT  = 4'd3;
    localparam logic [3:0] S_DEL_CAPT  = 4'd4;
    localparam logic [3:0] S_DEL_MOVE  = 4'd5;
    localparam logic [3:0] S_DEL_LAST  = 4'd6;
    localparam logic [3:0] S_LOC_RUN   = 4'd7;
    localparam logic [3:0] S_LOC_TAIL  = 4'd8;
    localparam logic [3:0] S_INS_MOVE  = 4'd9;
    localparam logic [3:0] S_INS_LAST  = 4'd10;
    localparam logic [3:0] S_INS_WRITE = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_DONE;
                case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.clr_count = 1'b1;
                    end
                    MODE_GET, MODE_DELETE:
                    begin
                        if (stat.get_ok)
                        begin
                            cmd.ptr_load_pos = 1'b1;
                            state_next       = S_RD_ISSUE;
                        end
                    end
                    MODE_LOCATE:
                    begin
                        if (!stat.count_zero)
                        begin
                            cmd.ptr_load_zero = 1'b1;
                            state_next        = S_LOC_RUN;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (stat.ins_ok && stat.ins_tail)
                        begin
                            state_next = S_INS_WRITE;
                        end
                        else if (stat.ins_ok)
                        begin
                            cmd.ptr_load_cnt = 1'b1;
                            state_next       = S_INS_MOVE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RD_ISSUE:
            begin
                cmd.issue  = 1'b1;
                cmd.dir_up = 1'b1;
                state_next = (stat.mode == MODE_GET) ? S_GET_CAPT : S_DEL_CAPT;
            end
            S_GET_CAPT:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_DEL_CAPT:
            begin
                cmd.capture = 1'b1;
                if (stat.del_more)
                begin
                    cmd.issue  = 1'b1;
                    cmd.dir_up = 1'b1;
                    state_next = stat.ptr_last_cnt ? S_DEL_LAST : S_DEL_MOVE;
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DEL_MOVE:
            begin
                cmd.issue    = 1'b1;
                cmd.dir_up   = 1'b1;
                cmd.shift_wr = 1'b1;
                if (stat.ptr_last_cnt)
                begin
                    state_next = S_DEL_LAST;
                end
            end
            S_DEL_LAST:
            begin
                cmd.shift_wr  = 1'b1;
                cmd.dec_count = 1'b1;
                state_next    = S_DONE;
            end
            S_LOC_RUN:
            begin
                cmd.issue  = 1'b1;
                cmd.dir_up = 1'b1;
                if (stat.hit)
                begin
                    cmd.found_rec = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.ptr_last_cnt)
                begin
                    state_next = S_LOC_TAIL;
                end
            end
            S_LOC_TAIL:
            begin
                cmd.found_rec = stat.hit;
                state_next    = S_DONE;
            end
            S_INS_MOVE:
            begin
                cmd.issue    = 1'b1;
                cmd.shift_wr = 1'b1;
                cmd.shift_up = 1'b1;
                if (stat.ptr_last_pos)
                begin
                    state_next = S_INS_LAST;
                end
            end
            S_INS_LAST:
            begin
                cmd.shift_wr = 1'b1;
                cmd.shift_up = 1'b1;
                state_next   = S_INS_WRITE;
            end
            S_INS_WRITE:
            begin
                cmd.wr_value  = 1'b1;
                cmd.inc_count = 1'b1;
                state_next    = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = !(state_reg inside {S_IDLE, S_DONE});
    assign done = (state_reg == S_DONE);

endmodule : ale_ctrl
`default_nettype wire

>>> hw/rtl/ale_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array list engine datapath
// Element memory, length counter, scan pointer and result registers.
// ----------------------------------------------------------------------------
module ale_dpath
    import ale_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ale_cmd_t                 cmd,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [DATA_W-1:0] item_value,
    output ale_stat_t                     stat,
    output logic                          ok,
    output logic signed [DATA_W-1:0]      read_value,
    output logic [LEN_W-1:0]              found_position,
    output logic [LEN_W-1:0]              list_length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [MODE_W-1:0]        mode_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            ptr_reg;
    logic [AW-1:0]            tag_reg;
    logic                     rvalid_reg;
    logic signed [DATA_W-1:0] mem_q_reg;
    logic                     ok_reg;
    logic signed [DATA_W-1:0] rdval_reg;
    logic [LEN_W-1:0]         found_reg;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic [WW-1:0]            pos_w;
    logic [WW-1:0]            cnt_w;
    logic [WW-1:0]            pos_m1_w;
    logic [WW-1:0]            cnt_m1_w;
    logic [WW-1:0]            tag_p1_w;
    logic                     op_ok;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;

    assign pos_w    = WW'(pos_reg);
    assign cnt_w    = WW'(count_reg);
    assign pos_m1_w = pos_w - WW'(1);
    assign cnt_m1_w = cnt_w - WW'(1);
    assign tag_p1_w = WW'(tag_reg) + WW'(1);

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.get_ok       = (pos_w != '0) && (pos_w <= cnt_w);
        stat.ins_ok       = (cnt_w < WW'(CAPACITY)) && (pos_w != '0)
                            && (pos_w <= cnt_w + WW'(1));
        stat.ins_tail     = (pos_w == cnt_w + WW'(1));
        stat.del_more     = (pos_w != cnt_w);
        stat.count_zero   = (count_reg == '0);
        stat.ptr_last_cnt = (ptr_reg == cnt_m1_w[AW-1:0]);
        stat.ptr_last_pos = (ptr_reg == pos_m1_w[AW-1:0]);
        stat.hit          = rvalid_reg && (mem_q_reg == value_reg);
    end

    always_comb
    begin
        case (mode_reg)
            MODE_CLEAR, MODE_LOCATE: op_ok = 1'b1;
            MODE_GET, MODE_DELETE:   op_ok = stat.get_ok;
            MODE_INSERT:             op_ok = stat.ins_ok;
            default:                 op_ok = 1'b0;
        endcase
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            pos_reg   <= position;
            value_reg <= item_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.issue;
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.inc_count)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ptr_load_pos)
        begin
            ptr_reg <= pos_m1_w[AW-1:0];
        end
        else if (cmd.ptr_load_cnt)
        begin
            ptr_reg <= cnt_m1_w[AW-1:0];
        end
        else if (cmd.ptr_load_zero)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            ptr_reg <= cmd.dir_up ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
        end
    end

    // Element memory: one write port, one registered read port.
    assign we    = (cmd.shift_wr && rvalid_reg) || cmd.wr_value;
    assign waddr = cmd.wr_value ? pos_m1_w[AW-1:0]
                 : (cmd.shift_up ? tag_reg + AW'(1) : tag_reg - AW'(1));
    assign wdata = cmd.wr_value ? value_reg : mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[ptr_reg];
        tag_reg   <= ptr_reg;
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            ok_reg    <= op_ok;
            rdval_reg <= '0;
            found_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rdval_reg <= mem_q_reg;
            end
            if (cmd.found_rec)
            begin
                found_reg <= tag_p1_w[LEN_W-1:0];
            end
        end
    end

    assign ok             = ok_reg;
    assign read_value     = rdval_reg;
    assign found_position = found_reg;
    assign list_length    = cnt_w[LEN_W-1:0];

endmodule : ale_dpath
`default_nettype wire

>>> hw/rtl/array_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array list engine
// Ordered list of signed 32-bit values with clear, get, locate, insert and
// delete requests at 1-based positions.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Its single
// result is shown on ok, read_value, found_position and list_length for
// exactly one cycle while done is high; the receiver cannot stall it, so it
// must take the result in that cycle. busy is low during the done cycle, so
// the next request may be issued there. Clear and a failed request go from
// decode straight to done; get reads one entry, delete also shifts the
// entries above it down, insert shifts entries up first when any must move,
// and locate stops at its first hit. The element memory has a single read
// port and a single write port, and the scans and shifts stream one entry per
// cycle through it, so the list length sets the cost of locate, insert and
// delete. No clearing pass is needed after reset: only entries below the
// length are ever read, and those were written by an insert.
// ----------------------------------------------------------------------------
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [DATA_W-1:0] item_value,
    output logic                          done,
    output logic                          ok,
    output logic signed [DATA_W-1:0]      read_value,
    output logic [LEN_W-1:0]              found_position,
    output logic [LEN_W-1:0]              list_length
);

    // Command and status bundles between the sequencer and the datapath.
    ale_cmd_t  cmd;
    ale_stat_t stat;

    // The controller owns all sequencing: decode, the pipelined scan for
    // locate and the streaming shifts for insert and delete.
    ale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the element memory, the length and the results.
    ale_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .position       (position),
        .item_value     (item_value),
        .stat           (stat),
        .ok             (ok),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length)
    );

    // An accepted request keeps the engine busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a request");

    // The result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // A failed request never reports a read value.
    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == '0))
        else $error("failed request reports a read value");

    // A found position only comes with a successful locate.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (found_position != '0)) |-> ok)
        else $error("found position reported on a failed request");

    // The requester sees no change of the request latch while busy.
    a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load)
        else $error("request latched while busy");

endmodule : array_list_engine
`default_nettype wire

>>> tb/array_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array list engine testbench
// Drives clear, get, locate, insert and delete requests through the start and
// busy handshake and checks every done strobe against a shadow copy of the
// list kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module array_list_engine_test;
    import ale_pkg::*;

    localparam int LIST_CAP = 32;

    // Highest code the mode field can carry; everything above MODE_DELETE is
    // an unknown operation that the block must reject.
    localparam logic [MODE_W-1:0] MODE_TOP = '1;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam int RANDOM_REQUESTS = 1450;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
    logic                     done;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         found_position;
    logic [LEN_W-1:0]         list_length;

    // One result as the block should report it.
    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         found_position;
        logic [LEN_W-1:0]         list_length;
    } list_result_t;

    // The class keeps its own copy of the list. Each accepted request is
    // applied to that copy at once and the result it should produce is queued;
    // each done strobe is then compared with the oldest queued result.
    class list_shadow;
        logic signed [DATA_W-1:0] entries [LIST_CAP];
        int unsigned              fill;
        list_result_t             pending_results [$];
        int                       errors;
        int                       requests;
        int                       full_rejects;
        int unsigned              peak_fill;

        function new();
            fill         = 0;
            errors       = 0;
            requests     = 0;
            full_rejects = 0;
            peak_fill    = 0;
            foreach (entries[k])
                entries[k] = '0;
        endfunction

        function void apply_request(input logic [MODE_W-1:0] m,
                                    input logic [POS_W-1:0] p,
                                    input logic signed [DATA_W-1:0] v);
            list_result_t r;
            int unsigned  k;
            int unsigned  pos;
            bit           hit;
            r.ok             = 1'b0;
            r.read_value     = '0;
            r.found_position = '0;
            pos              = p;
            hit              = 1'b0;
            requests++;
            case (m)
                MODE_CLEAR:
                begin
                    fill = 0;
                    r.ok = 1'b1;
                end
                MODE_GET:
                begin
                    if (pos >= 1 && pos <= fill)
                    begin
                        r.read_value = entries[pos-1];
                        r.ok         = 1'b1;
                    end
                end
                MODE_LOCATE:
                begin
                    r.ok = 1'b1;
                    for (k = 0; k < fill; k++)
                    begin
                        if (!hit && entries[k] == v)
                        begin
                            r.found_position = LEN_W'(k + 1);
                            hit              = 1'b1;
                        end
                    end
                end
                MODE_INSERT:
                begin
                    if (fill < LIST_CAP && pos >= 1 && pos <= fill + 1)
                    begin
                        for (k = fill; k > pos - 1; k--)
                            entries[k] = entries[k-1];
                        entries[pos-1] = v;
                        fill++;
                        r.ok = 1'b1;
                    end
                    else if (fill == LIST_CAP)
                        full_rejects++;
                end
                MODE_DELETE:
                begin
                    if (pos >= 1 && pos <= fill)
                    begin
                        r.read_value = entries[pos-1];
                        for (k = pos - 1; k + 1 < fill; k++)
                            entries[k] = entries[k+1];
                        fill--;
                        r.ok = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (fill > peak_fill)
                peak_fill = fill;
            r.list_length = LEN_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic a_ok,
                                   input logic signed [DATA_W-1:0] a_read,
                                   input logic [LEN_W-1:0] a_found,
                                   input logic [LEN_W-1:0] a_len);
            list_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("done strobe with no request outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (a_ok !== e.ok)
            begin
                $error("ok: expected %0d, actual %0d", e.ok, a_ok);
                errors++;
            end
            if (a_read !== e.read_value)
            begin
                $error("read_value: expected %0d, actual %0d", e.read_value, a_read);
                errors++;
            end
            if (a_found !== e.found_position)
            begin
                $error("found_position: expected %0d, actual %0d",
                       e.found_position, a_found);
                errors++;
            end
            if (a_len !== e.list_length)
            begin
                $error("list_length: expected %0d, actual %0d", e.list_length, a_len);
                errors++;
            end
        endfunction
    endclass

    list_shadow shadow;

    // When set, the sender issues requests back to back with no idle cycles.
    bit back_to_back;

    array_list_engine #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .position       (position),
        .item_value     (item_value),
        .done           (done),
        .ok             (ok),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: a hung handshake or a lost done strobe ends the run here.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Everything is sampled at the rising edge, so the values seen are the
    // ones that were stable during the cycle just ended. A result is checked
    // before the request accepted at the same edge is applied, which keeps
    // the queue order equal to the order of the done strobes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                shadow.check_result(ok, read_value, found_position, list_length);
            if (start && !busy)
                shadow.apply_request(mode, position, item_value);
        end
    end

    // Offers one request and returns at the edge that accepts it. A random
    // number of idle cycles comes first, during which the payload ports carry
    // junk so that a block that samples them early is caught.
    task automatic issue_request(input logic [MODE_W-1:0] m,
                                 input logic [POS_W-1:0] p,
                                 input logic signed [DATA_W-1:0] v);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start      <= 1'b0;
            mode       <= MODE_W'($urandom);
            position   <= POS_W'($urandom);
            item_value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        position   <= p;
        item_value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Holds the sender off until every outstanding result has come back. The
    // queue is looked at just after the edge so that the monitor has already
    // run, and the task returns on an edge so that driving stays aligned.
    task automatic wait_for_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            #1;
        end
        while (shadow.pending_results.size() != 0);
        @(posedge clk);
    endtask

    // Values lean on the extremes and on a small pool so that duplicates
    // appear in the list and locate has to report the first of them.
    function automatic logic signed [DATA_W-1:0] draw_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return DATA_W'($signed($urandom_range(0, 7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // Positions are mostly valid for the current length; one in ten is a
    // bad one: zero, just past the end, or anything the field can hold.
    function automatic logic [POS_W-1:0] draw_position(input int unsigned top);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0 || top == 0)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return POS_W'(top + 1);
                default: return POS_W'($urandom_range(0, (1 << POS_W) - 1));
            endcase
        end
        return POS_W'($urandom_range(1, top));
    endfunction

    initial
    begin
        int               i;
        int               m;
        int               sel;
        int               w;
        int unsigned      cnt;
        bit               grow;
        logic [MODE_W-1:0]        r_mode;
        logic [POS_W-1:0]         r_pos;
        logic signed [DATA_W-1:0] r_val;

        shadow       = new();
        back_to_back = 1'b0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        mode       <= MODE_CLEAR;
        position   <= '0;
        item_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty list corner cases, bad positions, inserts at
        // the front, middle and tail, duplicate values, deletes at every end,
        // unknown modes and a clear of a populated list.
        issue_request(MODE_CLEAR,  6'd0,  '0);
        issue_request(MODE_GET,    6'd1,  '0);
        issue_request(MODE_DELETE, 6'd1,  '0);
        issue_request(MODE_LOCATE, 6'd0,  '0);
        issue_request(MODE_INSERT, 6'd0,  32'sd5);
        issue_request(MODE_INSERT, 6'd2,  32'sd5);
        issue_request(MODE_INSERT, 6'd1,  VAL_MAX);
        issue_request(MODE_INSERT, 6'd1,  VAL_MIN);
        issue_request(MODE_INSERT, 6'd3,  '0);
        issue_request(MODE_INSERT, 6'd2,  '1);
        issue_request(MODE_INSERT, 6'd5,  VAL_MAX);
        issue_request(MODE_GET,    6'd1,  '0);
        issue_request(MODE_GET,    6'd5,  '0);
        issue_request(MODE_GET,    6'd6,  '0);
        issue_request(MODE_GET,    '1,    '1);
        issue_request(MODE_LOCATE, 6'd0,  VAL_MAX);
        issue_request(MODE_LOCATE, 6'd0,  32'sd12345);
        issue_request(MODE_DELETE, 6'd3,  '0);
        issue_request(MODE_DELETE, 6'd4,  '0);
        issue_request(MODE_DELETE, 6'd1,  '0);
        issue_request(MODE_DELETE, 6'd0,  '0);
        for (m = MODE_DELETE + 1; m <= MODE_TOP; m++)
            issue_request(MODE_W'(m), 6'd1, VAL_MAX);
        issue_request(MODE_CLEAR,  6'd0,  '0);
        issue_request(MODE_GET,    6'd1,  '0);
        wait_for_results();

        // Random part. The mix swings between a growing phase, where inserts
        // dominate until the store is full, and a shrinking phase, where
        // deletes dominate until it is empty; full-store inserts and the
        // widest positions are reached on the way.
        grow = 1'b1;
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 100 == 0)
                back_to_back = ($urandom_range(0, 3) == 0);
            if (i % 300 == 150)
                wait_for_results();
            cnt = shadow.fill;
            if (grow && cnt == LIST_CAP)
                grow = 1'b0;
            else if (!grow && cnt == 0)
                grow = 1'b1;
            sel   = $urandom_range(0, 99);
            r_val = draw_value();
            r_pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            if (sel < 2)
                r_mode = MODE_W'($urandom_range(MODE_DELETE + 1, MODE_TOP));
            else if (sel == 2 && !grow)
                r_mode = MODE_CLEAR;
            else if (sel < (grow ? 50 : 15))
            begin
                r_mode = MODE_INSERT;
                r_pos  = draw_position(cnt + 1);
            end
            else if (sel < 60)
            begin
                r_mode = MODE_DELETE;
                r_pos  = draw_position(cnt);
            end
            else if (sel < 80)
            begin
                r_mode = MODE_GET;
                r_pos  = draw_position(cnt);
            end
            else
            begin
                r_mode = MODE_LOCATE;
                if (cnt > 0 && $urandom_range(0, 9) < 6)
                    r_val = shadow.entries[$urandom_range(0, cnt - 1)];
            end
            issue_request(r_mode, r_pos, r_val);
        end

        // Let the last results drain, then watch a little longer for any
        // stray strobe before judging the run.
        wait_for_results();
        for (w = 0; w < 1000 && shadow.pending_results.size() != 0; w++)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (shadow.pending_results.size() != 0)
        begin
            $error("%0d results never arrived", shadow.pending_results.size());
            shadow.errors++;
        end

        $display("Checked %0d requests over all five operations and unknown modes.",
                 shadow.requests);
        $display("Longest list held %0d entries; %0d inserts hit a full store.",
                 shadow.peak_fill, shadow.full_rejects);
        if (shadow.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
